### rtl/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Implication that holds in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

### rtl/pae_pkg.sv
// Shared types and codes for the prefix autocomplete engine.
package pae_pkg;

  localparam logic [1:0] KIND_LOAD  = 2'd0;
  localparam logic [1:0] KIND_QUERY = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_LOOP, S_CLEN, S_CCMP, S_SINIT, S_SCAN, S_EMIT, S_NONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_INIT, OP_MID, OP_FIN, OP_CSTART, OP_CSTEP,
    OP_SINIT, OP_SCAN, OP_EMIT, OP_NONE
  } op_t;

  typedef struct packed {
    logic start_query;
    logic start_empty;
    logic loop_go;
    logic fin_bad;
    logic cmp_done;
    logic cmp_eq;
    logic fin;
    logic phase;
    logic range_bad;
    logic scan_last;
    logic emit_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/prefix_autocomplete_engine_top.sv
// Prefix autocomplete engine: a sorted weighted term table answered by prefix range search.
// Load, clear and non-final query words are taken while the engine is idle. The final
// word of a query starts two binary searches over the table, unless the prefix or the
// table is empty; each probe compares the term with the prefix one character per cycle
// (up to log2(TABLE_DEPTH)+2 probes per search). The matches are then emitted by weight,
// highest first and lower index first on ties, each result taking one scan of the
// matching range, so the emission phase scans the range once per match. No new word is
// taken until the last result has entered the output register.
module prefix_autocomplete_engine_top #(
  parameter int TABLE_DEPTH = 64,
  parameter int TERM_LEN    = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  char_code,
  input  logic        is_last,
  input  logic        empty_req,
  input  logic [31:0] term_weight,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        status,
  output logic [5:0]  match_index,
  output logic [31:0] match_weight,
  output logic [6:0]  match_count,
  output logic        last_result
);
  import pae_pkg::*;

  op_t        op;
  dp_status_t st;

  pae_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .st       (st),
    .in_ready (in_ready),
    .op       (op)
  );

  pae_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .TERM_LEN    (TERM_LEN)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .char_code    (char_code),
    .is_last      (is_last),
    .empty_req    (empty_req),
    .term_weight  (term_weight),
    .op           (op),
    .st           (st),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .match_index  (match_index),
    .match_weight (match_weight),
    .match_count  (match_count),
    .last_result  (last_result)
  );

endmodule

### rtl/pae_ctrl.sv
// Sequencer for loads, the two binary searches and the ordered emission.
module pae_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pae_pkg::dp_status_t st,
  output logic                in_ready,
  output pae_pkg::op_t        op
);
  import pae_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid && st.start_query) state_next = S_START;
      S_START: state_next = st.start_empty ? S_NONE : S_LOOP;
      S_LOOP: begin
        if (st.loop_go)      state_next = S_CLEN;
        else if (st.fin_bad) state_next = S_NONE;
        else                 state_next = S_CLEN;
      end
      S_CLEN:  state_next = S_CCMP;
      S_CCMP: begin
        if (st.cmp_done) begin
          priority if (!st.fin)     state_next = S_LOOP;
          else if (!st.cmp_eq)      state_next = S_NONE;
          else if (!st.phase)       state_next = S_LOOP;
          else if (st.range_bad)    state_next = S_NONE;
          else                      state_next = S_SINIT;
        end
      end
      S_SINIT: state_next = S_SCAN;
      S_SCAN:  if (st.scan_last) state_next = S_EMIT;
      S_EMIT:  if (st.out_free) state_next = st.emit_last ? S_IDLE : S_SINIT;
      S_NONE:  if (st.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = OP_NOP;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_START: op = st.start_empty ? OP_NOP : OP_INIT;
      S_LOOP: begin
        if (st.loop_go)       op = OP_MID;
        else if (!st.fin_bad) op = OP_FIN;
      end
      S_CLEN:  op = OP_CSTART;
      S_CCMP:  op = OP_CSTEP;
      S_SINIT: op = OP_SINIT;
      S_SCAN:  op = OP_SCAN;
      S_EMIT:  if (st.out_free) op = OP_EMIT;
      S_NONE:  if (st.out_free) op = OP_NONE;
      default: op = OP_NOP;
    endcase
  end

endmodule

### rtl/pae_dp.sv
// Term stores, prefix store, search registers, compare unit and result register.
module pae_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int TERM_LEN    = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic [1:0]          kind,
  input  logic [7:0]          char_code,
  input  logic                is_last,
  input  logic                empty_req,
  input  logic [31:0]         term_weight,
  input  pae_pkg::op_t        op,
  output pae_pkg::dp_status_t st,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                status,
  output logic [5:0]          match_index,
  output logic [31:0]         match_weight,
  output logic [6:0]          match_count,
  output logic                last_result
);
  import pae_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = $clog2(TERM_LEN + 1);
  localparam int PW = $clog2(TERM_LEN);
  localparam int CHARS = TABLE_DEPTH * TERM_LEN;
  localparam int AW = $clog2(CHARS);

  logic [7:0]    term_chars [CHARS];
  logic [LW-1:0] term_lengths [TABLE_DEPTH];
  logic [31:0]   term_weights [TABLE_DEPTH];
  logic [7:0]    prefix_chars [TERM_LEN];

  logic [CW-1:0] entry_count;
  logic [LW-1:0] load_position, prefix_length;
  logic [CW-1:0] left, r1, lo, emitted;
  logic [IW-1:0] cmp_idx, sidx, best_idx, prev_idx;
  logic [LW-1:0] ci;
  logic          fin, phase, have_prev, best_valid;
  logic [31:0]   best_w, prev_w;

  logic [7:0]    t_rd, p_rd;
  logic [LW-1:0] len_rd;
  logic [31:0]   w_rd;

  logic          in_fire, load_ok, load_store, pre_store;
  logic [LW-1:0] lp_inc, ci_sel;
  logic [AW-1:0] ch_waddr, ch_raddr;
  logic [IW-1:0] w_raddr;
  logic [CW:0]   mid_sum;
  logic          cmp_lt, cmp_eq, cmp_done, go_right;
  logic          eligible, better;

  assign in_fire    = in_valid && in_ready;
  assign load_ok    = in_fire && (kind == KIND_LOAD) && (entry_count < CW'(TABLE_DEPTH));
  assign load_store = load_ok && !empty_req && (load_position < LW'(TERM_LEN));
  assign pre_store  = in_fire && (kind == KIND_QUERY) && !empty_req &&
                      (prefix_length < LW'(TERM_LEN));
  assign lp_inc     = load_store ? load_position + 1'b1 : load_position;
  assign ch_waddr   = AW'(IW'(entry_count) * TERM_LEN) + AW'(load_position);
  assign ci_sel     = (op == OP_CSTART) ? '0 : ci + 1'b1;
  assign ch_raddr   = AW'(cmp_idx * TERM_LEN) + AW'(ci_sel);
  assign w_raddr    = (op == OP_SINIT) ? IW'(lo) : sidx + 1'b1;
  assign mid_sum    = ({1'b0, left} + {1'b0, r1} - 1'b1) >> 1;

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    if (load_store) term_chars[ch_waddr] <= char_code;
    t_rd <= term_chars[ch_raddr];
  end

  always_ff @(posedge clk) begin
    if (load_ok && is_last) begin
      term_lengths[IW'(entry_count)] <= lp_inc;
      term_weights[IW'(entry_count)] <= term_weight;
    end
    len_rd <= term_lengths[cmp_idx];
    w_rd   <= term_weights[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (pre_store) prefix_chars[PW'(prefix_length)] <= char_code;
    p_rd <= prefix_chars[PW'(ci_sel)];
  end

  // Compare of one term against the prefix, one character per cycle.
  always_comb begin
    cmp_done = 1'b1;
    cmp_lt   = 1'b0;
    cmp_eq   = 1'b0;
    priority if (ci == prefix_length) cmp_eq = 1'b1;
    else if (ci >= len_rd)            cmp_lt = 1'b1;
    else if (t_rd < p_rd)             cmp_lt = 1'b1;
    else if (t_rd > p_rd)             cmp_lt = 1'b0;
    else                              cmp_done = 1'b0;
  end

  assign go_right = phase ? (cmp_lt || cmp_eq) : cmp_lt;
  assign eligible = !have_prev || (w_rd < prev_w) || ((w_rd == prev_w) && (sidx > prev_idx));
  assign better   = !best_valid || (w_rd > best_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count   <= '0;
      load_position <= '0;
      prefix_length <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        unique case (kind)
          KIND_LOAD: begin
            if (load_ok) begin
              load_position <= is_last ? '0 : lp_inc;
              if (is_last) entry_count <= entry_count + 1'b1;
            end
          end
          KIND_QUERY: if (pre_store) prefix_length <= prefix_length + 1'b1;
          KIND_CLEAR: begin
            entry_count   <= '0;
            load_position <= '0;
          end
          default: ;
        endcase
      end
      if (op == OP_EMIT || op == OP_NONE) begin
        out_valid <= 1'b1;
        if (op == OP_NONE || st.emit_last) prefix_length <= '0;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_INIT: begin
        phase <= 1'b0;
        left  <= '0;
        r1    <= entry_count;
      end
      OP_MID: begin
        cmp_idx <= IW'(mid_sum);
        fin     <= 1'b0;
      end
      OP_FIN: begin
        cmp_idx <= phase ? IW'(r1 - 1'b1) : IW'(left);
        fin     <= 1'b1;
      end
      OP_CSTART: ci <= '0;
      OP_CSTEP: begin
        if (!cmp_done) ci <= ci + 1'b1;
        else if (!fin) begin
          if (go_right) left <= CW'(cmp_idx) + 1'b1;
          else          r1   <= CW'(cmp_idx);
        end else if (cmp_eq && !phase) begin
          lo    <= left;
          phase <= 1'b1;
          left  <= '0;
          r1    <= entry_count;
        end else if (cmp_eq) begin
          have_prev <= 1'b0;
          emitted   <= '0;
        end
      end
      OP_SINIT: begin
        sidx       <= IW'(lo);
        best_valid <= 1'b0;
      end
      OP_SCAN: begin
        sidx <= sidx + 1'b1;
        if (eligible && better) begin
          best_valid <= 1'b1;
          best_w     <= w_rd;
          best_idx   <= sidx;
        end
      end
      OP_EMIT: begin
        have_prev    <= 1'b1;
        prev_w       <= best_w;
        prev_idx     <= best_idx;
        emitted      <= emitted + 1'b1;
        status       <= 1'b0;
        match_index  <= 6'(best_idx);
        match_weight <= best_w;
        match_count  <= 7'(r1 - lo);
        last_result  <= st.emit_last;
      end
      OP_NONE: begin
        status       <= 1'b1;
        match_index  <= '0;
        match_weight <= '0;
        match_count  <= '0;
        last_result  <= 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    st.start_query = (kind == KIND_QUERY) && is_last;
    st.start_empty = (prefix_length == '0) || (entry_count == '0);
    st.loop_go     = left < r1;
    st.fin_bad     = phase ? (r1 == '0) : (left >= entry_count);
    st.cmp_done    = cmp_done;
    st.cmp_eq      = cmp_eq;
    st.fin         = fin;
    st.phase       = phase;
    st.range_bad   = r1 <= lo;
    st.scan_last   = CW'(sidx) == r1 - 1'b1;
    st.emit_last   = emitted + 1'b1 == r1 - lo;
    st.out_free    = !out_valid || out_ready;
  end

endmodule

### rtl/pae_checker.sv
// Port-level checks for the prefix autocomplete engine, bound to the top level.
`include "assert_macros.svh"

module pae_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic [31:0] match_weight,
  input logic [6:0]  match_count,
  input logic        last_result
);

  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && !out_ready) |=> (out_valid && $stable(match_weight)), "Result word changed while stalled.")
  `ASSERT_IMPL(a_none_form, clk, rst, out_valid && status, last_result && (match_count == 7'd0), "No-match word is malformed.")
  `ASSERT_IMPL(a_match_count, clk, rst, out_valid && !status, match_count != 7'd0, "Match word carries a zero count.")
  `ASSERT_IMPL(a_more_is_match, clk, rst, out_valid && !last_result, !status, "Non-final word is not a match.")

endmodule

bind prefix_autocomplete_engine_top pae_checker u_pae_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .match_weight (match_weight),
  .match_count  (match_count),
  .last_result  (last_result)
);
